@@ sv/sfc_pkg.sv @@
// shared types and constants for the streaming fir convolver
// no dependencies; imported by sfc_mac and streaming_fir_convolver
package sfc_pkg;

    localparam int DEFAULT_NUM_TAPS = 64;
    localparam int SAMPLE_W         = 16;
    localparam int TAP_COUNT_W      = 7;
    localparam int TAP_INDEX_W      = 6;
    localparam int IN_DATA_W        = 24;
    localparam int PROD_W           = 32;
    localparam int ACC_W            = 40;
    localparam int ROUND_SHIFT      = 15;
    localparam int ROUND_W          = ACC_W - ROUND_SHIFT;

    localparam logic signed [ACC_W-1:0]   ROUND_BIAS = ACC_W'(1 << (ROUND_SHIFT - 1));
    localparam logic signed [ROUND_W-1:0] SAT_MAX    = ROUND_W'(32767);
    localparam logic signed [ROUND_W-1:0] SAT_MIN    = -ROUND_W'(32768);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic mask;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
    } mac_status_t;

endpackage

@@ sv/sfc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module sfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/sfc_mac.sv @@
// shared multiply-accumulate unit: registered product, then wide accumulator
// depends on sfc_pkg
module sfc_mac (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  sfc_pkg::mac_ctrl_t                        ctrl,
    input  logic signed [sfc_pkg::SAMPLE_W-1:0]       coef,
    input  logic signed [sfc_pkg::SAMPLE_W-1:0]       sample,
    output sfc_pkg::mac_status_t                      status,
    output logic signed [sfc_pkg::ACC_W-1:0]          acc
);

    import sfc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     pv_reg, pv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    always_comb
    begin
        prod_next = ctrl.mask ? PROD_W'(coef) * PROD_W'(sample) : '0;
        pv_next   = ctrl.valid;
        acc_next  = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign status.busy = pv_reg;
    assign acc         = acc_reg;

endmodule

@@ sv/streaming_fir_convolver.sv @@
// top level of the streaming fir convolver: sequencer, tap memories, rounding
// depends on sfc_pkg, sfc_ram and sfc_mac
//
// usage:
//   s_* channel takes items: tuser is the kind (0 sample, 1 coefficient write),
//   tdata holds tap_index and data_word. a coefficient write stores one tap,
//   restarts the sample history and gives no result.
//   each sample gives one result on m_*: tdata is the rounded, saturated q1.15
//   output, tuser flags clipping.
//   cfg_* writes tap_count and is always ready; write it only while idle (not enforced).
//   per sample, count being tap_count capped at NUM_TAPS: the single shared
//   multiplier walks one tap a cycle, then the pipeline drains through the ram
//   read and product registers into the accumulator, the sum is rounded into a
//   register and loaded into the output register. a zero count skips the walk
//   and the drain. the next item is taken only once the result is loaded.
//   reset: a clearing pass writes zero into every coefficient entry, one per
//   cycle, with s_tready low; history uses a fill count.
//   a stalled result sits in the output register while the next item is taken;
//   a finished sample waits for that register before it is loaded.
module streaming_fir_convolver #(
    parameter int NUM_TAPS = sfc_pkg::DEFAULT_NUM_TAPS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfc_pkg::IN_DATA_W-1:0]      s_tdata,   // tap_index[5:0], data_word[21:6]
    input  logic                               s_tuser,   // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sfc_pkg::SAMPLE_W-1:0]       m_tdata,   // filtered_sample[15:0]
    output logic                               m_tuser,   // saturated
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sfc_pkg::TAP_COUNT_W-1:0]    cfg_data   // tap_count[6:0]
);

    import sfc_pkg::*;

    localparam int AW   = $clog2(NUM_TAPS);
    localparam int FW   = $clog2(NUM_TAPS + 1);
    localparam int MAXC = (NUM_TAPS < 127) ? NUM_TAPS : 127;
    localparam int KW   = $clog2(MAXC + 1);

    state_t state_reg, state_next;

    logic [TAP_COUNT_W-1:0] tap_count_reg, tap_count_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [KW-1:0]          k_reg, k_next;
    logic                   v1_reg, v1_next;
    logic                   mask1_reg, mask1_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]    out_data_reg, out_data_next;
    logic                   out_sat_reg, out_sat_next;
    logic signed [ROUND_W-1:0] rounded_reg, rounded_next;

    logic [KW-1:0]              count;
    logic [KW-1:0]              k_inc;
    logic [TAP_INDEX_W-1:0]     in_index;
    logic [SAMPLE_W-1:0]        in_word;
    logic                       in_accept;

    logic                       coef_we;
    logic [AW-1:0]              coef_waddr;
    logic [SAMPLE_W-1:0]        coef_wdata;
    logic                       hist_we;
    logic [SAMPLE_W-1:0]        coef_rdata;
    logic [SAMPLE_W-1:0]        hist_rdata;

    mac_ctrl_t                  mac_ctrl;
    mac_status_t                mac_status;
    logic signed [ACC_W-1:0]    acc;

    assign in_index  = s_tdata[TAP_INDEX_W-1:0];
    assign in_word   = s_tdata[TAP_INDEX_W +: SAMPLE_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign count     = (32'(tap_count_reg) > MAXC) ? KW'(MAXC) : KW'(tap_count_reg);
    assign k_inc     = k_reg + KW'(1);

    always_comb
    begin
        state_next     = state_reg;
        tap_count_next = tap_count_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        k_next         = k_reg;
        v1_next        = 1'b0;
        mask1_next     = (FW'(k_reg) < fill_reg);
        m_valid_next   = m_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;
        rounded_next   = rounded_reg;
        coef_we        = 1'b0;
        coef_waddr     = AW'(in_index);
        coef_wdata     = in_word;
        hist_we        = 1'b0;
        mac_ctrl       = '0;

        if (cfg_valid)
        begin
            tap_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                coef_we    = 1'b1;
                coef_waddr = clr_reg;
                coef_wdata = '0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(NUM_TAPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == REQ_COEF)
                    begin
                        coef_we   = (32'(in_index) < NUM_TAPS);
                        pos_next  = '0;
                        fill_next = '0;
                    end
                    else
                    begin
                        hist_we        = 1'b1;
                        slot_next      = pos_reg;
                        pos_next       = (pos_reg == AW'(NUM_TAPS - 1)) ? '0 : pos_reg + AW'(1);
                        fill_next      = (fill_reg == FW'(NUM_TAPS)) ? fill_reg
                                                                     : fill_reg + FW'(1);
                        k_next         = '0;
                        mac_ctrl.clear = 1'b1;
                        state_next     = (count == '0) ? ST_ROUND : ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                v1_next   = 1'b1;
                k_next    = k_inc;
                slot_next = (slot_reg == '0) ? AW'(NUM_TAPS - 1) : slot_reg - AW'(1);
                if (k_inc == count)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !mac_status.busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                rounded_next = ROUND_W'((acc + ROUND_BIAS) >>> ROUND_SHIFT);
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    if (rounded_reg > SAT_MAX)
                    begin
                        out_data_next = SAMPLE_W'(SAT_MAX);
                        out_sat_next  = 1'b1;
                    end
                    else if (rounded_reg < SAT_MIN)
                    begin
                        out_data_next = SAMPLE_W'(SAT_MIN);
                        out_sat_next  = 1'b1;
                    end
                    else
                    begin
                        out_data_next = SAMPLE_W'(rounded_reg);
                        out_sat_next  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mac_ctrl.valid = v1_reg;
        mac_ctrl.mask  = mask1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            tap_count_reg <= '0;
            clr_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_count_reg <= tap_count_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            v1_reg        <= v1_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        mask1_reg    <= mask1_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
        rounded_reg  <= rounded_next;
    end

    sfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (AW'(k_reg)),
        .rdata (coef_rdata)
    );

    sfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (pos_reg),
        .wdata (in_word),
        .raddr (slot_reg),
        .rdata (hist_rdata)
    );

    sfc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (coef_rdata),
        .sample (hist_rdata),
        .status (mac_status),
        .acc    (acc)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule
